### design/hlfr_pkg.sv
// Shared types and constants for the header/length frame receiver.
`timescale 1ns / 1ps

package hlfr_pkg;

    localparam int COUNT_W    = 7;
    localparam int EXPECT_W   = 9;
    localparam int BYTE_W     = 8;
    localparam int OVERHEAD_W = 4;
    localparam int INDEX_W    = 6;

    localparam logic [BYTE_W-1:0]     HEADER_RESET   = 8'hAF;
    localparam logic [OVERHEAD_W-1:0] OVERHEAD_RESET = 4'd4;

    // Request commands.
    typedef enum logic [1:0] {
        CMD_BYTE    = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_READ    = 2'd2
    } t_command;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_HEADER   = 1'b0,
        CFG_OVERHEAD = 1'b1
    } t_cfg_reg;

    // Input request payload.
    typedef struct packed {
        t_command           command;
        logic [BYTE_W-1:0]  rx_byte;
        logic [INDEX_W-1:0] buf_index;
    } t_rx_item;

    // Result payload.
    typedef struct packed {
        logic               frame_done;
        logic [COUNT_W-1:0] byte_count;
        logic               header_seen;
        logic [BYTE_W-1:0]  read_data;
    } t_rx_result;

    // Frame status after one request.
    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] count;
        logic               in_frame;
    } t_frame_status;

    // Buffer write control.
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] data;
    } t_buf_wr;

endpackage

### design/hlfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hlfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/hlfr_ctrl.sv
// Frame state registers, configuration registers and per-request update logic.
`timescale 1ns / 1ps

module hlfr_ctrl #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  hlfr_pkg::t_rx_item              i_item,
    input  logic                            i_cfg_we,
    input  hlfr_pkg::t_cfg_reg              i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    output hlfr_pkg::t_frame_status         o_status,
    output hlfr_pkg::t_buf_wr               o_wr,
    output logic [$clog2(BUFFER_BYTES)-1:0] o_wr_addr
);

    import hlfr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam logic [COUNT_W-1:0]  COUNT_LIMIT = COUNT_W'(BUFFER_BYTES);
    localparam logic [EXPECT_W-1:0] EXPECT_IDLE = EXPECT_W'(BUFFER_BYTES);
    localparam logic [COUNT_W-1:0]  COUNT_LEN   = COUNT_W'(2);

    logic [BYTE_W-1:0]     r_header;
    logic [OVERHEAD_W-1:0] r_overhead;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_done;
    logic                  r_in_frame;
    logic [EXPECT_W-1:0]   r_expect;

    logic [COUNT_W-1:0]    n_count;
    logic                  n_done;
    logic                  n_in_frame;
    logic [EXPECT_W-1:0]   n_expect;
    logic [COUNT_W-1:0]    wr_pos;
    logic                  wr_en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header   <= HEADER_RESET;
            r_overhead <= OVERHEAD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HEADER:   r_header   <= i_cfg_data;
                CFG_OVERHEAD: r_overhead <= i_cfg_data[OVERHEAD_W-1:0];
                default:      r_header   <= r_header;
            endcase
        end
    end

    // Next frame state for the request at the input.
    always_comb begin
        n_count    = r_count;
        n_done     = r_done;
        n_in_frame = r_in_frame;
        n_expect   = r_expect;
        wr_pos     = '0;
        wr_en      = 1'b0;
        case (i_item.command)
            CMD_BYTE: begin
                if (!r_done && r_in_frame) begin
                    // Buffer full: restart at the first entry and drop the frame.
                    if (r_count >= COUNT_LIMIT) begin
                        n_count    = '0;
                        n_in_frame = 1'b0;
                        n_expect   = EXPECT_IDLE;
                    end
                    wr_en   = 1'b1;
                    wr_pos  = n_count;
                    n_count = n_count + COUNT_W'(1);
                    // The second byte carries the length.
                    if (n_count == COUNT_LEN) begin
                        n_expect = EXPECT_W'(i_item.rx_byte) + EXPECT_W'(r_overhead);
                    end
                    // Frame complete.
                    if (EXPECT_W'(n_count) == n_expect) begin
                        n_count    = n_count - COUNT_W'(1);
                        n_done     = 1'b1;
                        n_in_frame = 1'b0;
                        n_expect   = EXPECT_IDLE;
                    end
                end else if (!r_done && i_item.rx_byte == r_header) begin
                    // Header found: start collecting.
                    n_in_frame = 1'b1;
                    wr_en      = 1'b1;
                    wr_pos     = (r_count < COUNT_LIMIT) ? r_count : '0;
                    n_count    = r_count + COUNT_W'(1);
                end
            end
            CMD_RELEASE: begin
                n_count = '0;
                n_done  = 1'b0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_done     <= 1'b0;
            r_in_frame <= 1'b0;
            r_expect   <= EXPECT_IDLE;
        end else if (i_step) begin
            r_count    <= n_count;
            r_done     <= n_done;
            r_in_frame <= n_in_frame;
            r_expect   <= n_expect;
        end
    end

    assign o_status.done     = n_done;
    assign o_status.count    = n_count;
    assign o_status.in_frame = n_in_frame;
    assign o_wr.en           = wr_en & i_step;
    assign o_wr.data         = i_item.rx_byte;
    assign o_wr_addr         = AW'(wr_pos);

endmodule

### design/header_length_frame_receiver.sv
// Top level of the header/length frame receiver: handshakes, result register, buffer.
//
//  Channel  | Signals                                  | Role
//  ---------+------------------------------------------+------------------------------
//  in       | i_in_valid, o_in_ready, i_in             | byte, release or read request
//  out      | o_out_valid, i_out_ready, o_out          | status and read data per request
//  cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index,   | header byte and length overhead
//           | i_cfg_data                               |
//
// The frame update is combinational between the state registers and the result register;
// one request can be taken every cycle unless a stalled result holds the input off.
// The result appears in the cycle after its request; read data comes from the buffer's
// registered read port. A stalled result holds the input off only while it waits.
// Reset is synchronous and holds both ready outputs low; buffer contents are not
// cleared and hold garbage until written.
`timescale 1ns / 1ps

module header_length_frame_receiver #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hlfr_pkg::t_rx_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hlfr_pkg::t_rx_result o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  hlfr_pkg::t_cfg_reg   i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    import hlfr_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic                 step;
    t_frame_status        status;
    t_buf_wr              buf_wr;
    logic [AW-1:0]        buf_waddr;
    logic [BYTE_W-1:0]    buf_rdata;
    logic                 rd_hit;

    logic                 r_out_valid;
    t_frame_status        r_out_status;
    logic                 r_rd_sel;

    // A request is taken when the result register is empty or is being emptied.
    assign o_in_ready  = i_rst_n && (!r_out_valid || i_out_ready);
    assign step        = i_in_valid && o_in_ready;
    assign o_cfg_ready = i_rst_n;

    // Read requests inside the buffer return data; all others return zero.
    assign rd_hit = (i_in.command == CMD_READ) &&
                    (COUNT_W'(i_in.buf_index) < COUNT_W'(BUFFER_BYTES));

    hlfr_ctrl #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_wr        (buf_wr),
        .o_wr_addr   (buf_waddr)
    );

    hlfr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(BUFFER_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_wr.en),
        .i_waddr (buf_waddr),
        .i_wdata (buf_wr.data),
        .i_re    (step),
        .i_raddr (AW'(i_in.buf_index)),
        .o_rdata (buf_rdata)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded with each request.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_status <= status;
            r_rd_sel     <= rd_hit;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out.frame_done  = r_out_status.done;
    assign o_out.byte_count  = r_out_status.count;
    assign o_out.header_seen = r_out_status.in_frame;
    assign o_out.read_data   = r_rd_sel ? buf_rdata : '0;

endmodule

### design/hlfr_checker.sv
// Port-level assertions for the header/length frame receiver, bound to the top level.
`timescale 1ns / 1ps

module hlfr_checker #(
    parameter int BUFFER_BYTES = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input hlfr_pkg::t_rx_item   i_in,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input hlfr_pkg::t_rx_result o_out
);

    import hlfr_pkg::*;

    // A finished frame is never reported while a frame is being collected.
    a_done_not_collecting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.frame_done && o_out.header_seen))
        else $error("frame_done and header_seen both set");

    // A done frame reports a count inside the buffer.
    a_done_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.frame_done) |->
            (o_out.byte_count < COUNT_W'(BUFFER_BYTES)))
        else $error("done count outside the buffer");

    // Only a read request returns nonzero data.
    a_read_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.command != CMD_READ) |=>
            (o_out_valid && o_out.read_data == '0))
        else $error("read data on a non-read request");

    // A release request clears the count and the done flag.
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.command == CMD_RELEASE) |=>
            (o_out_valid && !o_out.frame_done && o_out.byte_count == '0))
        else $error("release did not clear status");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind header_length_frame_receiver hlfr_checker #(
    .BUFFER_BYTES(BUFFER_BYTES)
) u_hlfr_checker (.*);
